/* rtl/assert_macros.svh */
// Assertion macros shared by the tape interpreter RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define TLI_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tli assertion failed");

// Next-cycle implication.
`define TLI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tli assertion failed");

`endif

/* rtl/tli_pkg.sv */
// ----------------------------------------------------------------------------
// tli_pkg
// Shared codes and types for the tape language interpreter.
// ----------------------------------------------------------------------------
`default_nettype none

package tli_pkg;

	// Request codes
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// Machine status codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DONE  = 3'd2;
	localparam logic [2:0] ST_UNBAL = 3'd3;
	localparam logic [2:0] ST_POVF  = 3'd4;
	localparam logic [2:0] ST_NOVF  = 3'd5;

	// Command characters
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LBR   = 8'h5B;
	localparam logic [7:0] CH_RBR   = 8'h5D;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		DP_NOP,
		DP_CAPTURE,
		DP_LOAD,
		DP_PAIR_OPEN,
		DP_PAIR_CLOSE,
		DP_START,
		DP_CLEAR,
		DP_TICK_END,
		DP_EXEC
	} tli_op_t;

	// Datapath flags seen by the controller
	typedef struct packed {
		logic [1:0] req;
		logic       load_err;
		logic       pair_pending;
		logic       running;
		logic       can_run;
		logic       clear_last;
	} tli_sts_t;

endpackage

`default_nettype wire

/* rtl/tli_datapath.sv */
// ----------------------------------------------------------------------------
// tli_datapath
// Program store, partner table, bracket stack, tape and the run registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tli_datapath import tli_pkg::*; #(
	parameter int PROG_BYTES = 4096,
	parameter int TAPE_CELLS = 32768,
	parameter int NEST_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] req_type,
	input  wire logic [7:0] data_byte,
	input  wire logic       data_valid,
	input  wire logic       data_eof,
	input  wire tli_op_t    op,
	output tli_sts_t        sts,
	output logic [7:0]      out_byte,
	output logic            out_valid,
	output logic            need_input,
	output logic [2:0]      run_status
);

	localparam int PA = $clog2(PROG_BYTES);
	localparam int PW = $clog2(PROG_BYTES + 1);
	localparam int TA = $clog2(TAPE_CELLS);
	localparam int SA = $clog2(NEST_DEPTH);
	localparam int ST = $clog2(NEST_DEPTH + 1);

	logic [7:0]    prog_mem [PROG_BYTES];
	logic [PA:0]   pm_mem   [PROG_BYTES];
	logic [PA-1:0] stk_mem  [NEST_DEPTH];
	logic [7:0]    tape_mem [TAPE_CELLS];

	logic [1:0]    req_q;
	logic [7:0]    byte_q;
	logic          valid_q, eof_q;
	logic [PW-1:0] len_q, pc_q;
	logic [ST-1:0] top_q;
	logic [TA-1:0] cell_q, clr_q;
	logic [2:0]    status_q;
	logic [7:0]    out_byte_q;
	logic          out_valid_q, need_q;

	logic [7:0]    prog_rd_q, tape_rd_q;
	logic [PA:0]   pm_rd_q;
	logic [PA-1:0] stk_rd_q;

	logic          len_full, stack_full, stack_empty, is_lbr, is_rbr;
	logic [ST-1:0] top_dec;
	logic          prog_we, pm_we, stk_we, tape_we;
	logic [PA-1:0] pm_addr;
	logic [PA:0]   pm_wd;
	logic [TA-1:0] tape_addr;
	logic [7:0]    tape_wd;
	logic          loop_jump, cmd_matched;
	logic [PA-1:0] cmd_partner;

	function automatic logic data_valid_or_eof(input logic v, input logic e);
		return v | e;
	endfunction

	assign len_full    = (len_q == PW'(PROG_BYTES));
	assign stack_full  = (top_q == ST'(NEST_DEPTH));
	assign stack_empty = (top_q == '0);
	assign is_lbr      = (byte_q == CH_LBR);
	assign is_rbr      = (byte_q == CH_RBR);
	assign top_dec     = top_q - ST'(1);
	assign cmd_matched = pm_rd_q[PA];
	assign cmd_partner = pm_rd_q[PA-1:0];
	assign loop_jump   = ((prog_rd_q == CH_LBR) == (tape_rd_q == 8'd0));

	assign sts.req          = req_q;
	assign sts.load_err     = (status_q == ST_POVF) || (status_q == ST_NOVF);
	assign sts.pair_pending = !len_full && is_rbr && !stack_empty;
	assign sts.running      = (status_q == ST_RUN);
	assign sts.can_run      = (pc_q < len_q);
	assign sts.clear_last   = (clr_q == TA'(TAPE_CELLS - 1));

	// Write port selection
	always_comb begin
		prog_we   = 1'b0;
		pm_we     = 1'b0;
		stk_we    = 1'b0;
		tape_we   = 1'b0;
		pm_addr   = len_q[PA-1:0];
		pm_wd     = '0;
		tape_addr = cell_q;
		tape_wd   = 8'd0;
		case (op)
			DP_LOAD: begin
				if (!len_full) begin
					if (is_lbr) begin
						stk_we  = !stack_full;
						pm_we   = !stack_full;
						prog_we = !stack_full;
					end else if (is_rbr) begin
						pm_we   = stack_empty;
						prog_we = stack_empty;
					end else begin
						prog_we = 1'b1;
					end
				end
			end
			DP_PAIR_OPEN: begin
				pm_we   = 1'b1;
				pm_addr = stk_rd_q;
				pm_wd   = {1'b1, len_q[PA-1:0]};
			end
			DP_PAIR_CLOSE: begin
				pm_we   = 1'b1;
				prog_we = 1'b1;
				pm_wd   = {1'b1, stk_rd_q};
			end
			DP_CLEAR: begin
				tape_we   = 1'b1;
				tape_addr = clr_q;
			end
			DP_EXEC: begin
				case (prog_rd_q)
					CH_PLUS: begin
						tape_we = 1'b1;
						tape_wd = tape_rd_q + 8'd1;
					end
					CH_MINUS: begin
						tape_we = 1'b1;
						tape_wd = tape_rd_q - 8'd1;
					end
					CH_COMMA: begin
						tape_we = data_valid_or_eof(valid_q, eof_q);
						tape_wd = valid_q ? byte_q : 8'hFF;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Memories
	always_ff @(posedge clk) begin
		if (prog_we)
			prog_mem[len_q[PA-1:0]] <= byte_q;
		prog_rd_q <= prog_mem[pc_q[PA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pm_we)
			pm_mem[pm_addr] <= pm_wd;
		pm_rd_q <= pm_mem[pc_q[PA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[top_q[SA-1:0]] <= len_q[PA-1:0];
		if (op == DP_LOAD)
			stk_rd_q <= stk_mem[top_dec[SA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (tape_we)
			tape_mem[tape_addr] <= tape_wd;
		tape_rd_q <= tape_mem[cell_q];
	end

	// Captured item payload
	always_ff @(posedge clk) begin
		if (op == DP_CAPTURE) begin
			byte_q  <= data_byte;
			valid_q <= data_valid;
			eof_q   <= data_eof;
		end
	end

	// Run registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q       <= REQ_LOAD;
			len_q       <= '0;
			pc_q        <= '0;
			top_q       <= '0;
			cell_q      <= '0;
			clr_q       <= '0;
			status_q    <= ST_IDLE;
			out_byte_q  <= 8'd0;
			out_valid_q <= 1'b0;
			need_q      <= 1'b0;
		end else begin
			case (op)
				DP_CAPTURE: begin
					req_q       <= req_type;
					out_byte_q  <= 8'd0;
					out_valid_q <= 1'b0;
					need_q      <= 1'b0;
				end
				DP_LOAD: begin
					if (len_full) begin
						status_q <= ST_POVF;
					end else if (is_lbr) begin
						if (stack_full) begin
							status_q <= ST_NOVF;
						end else begin
							top_q <= top_q + ST'(1);
							len_q <= len_q + PW'(1);
						end
					end else if (is_rbr && !stack_empty) begin
						top_q <= top_dec;
					end else begin
						len_q <= len_q + PW'(1);
					end
				end
				DP_PAIR_CLOSE: len_q <= len_q + PW'(1);
				DP_START: begin
					clr_q    <= '0;
					cell_q   <= '0;
					pc_q     <= '0;
					status_q <= ST_RUN;
				end
				DP_CLEAR: clr_q <= clr_q + TA'(1);
				DP_TICK_END: status_q <= ST_DONE;
				DP_EXEC: begin
					pc_q <= pc_q + PW'(1);
					case (prog_rd_q)
						CH_LT: cell_q <= (cell_q == '0) ? TA'(TAPE_CELLS - 1) : cell_q - TA'(1);
						CH_GT: cell_q <= (cell_q == TA'(TAPE_CELLS - 1)) ? '0 : cell_q + TA'(1);
						CH_DOT: begin
							out_byte_q  <= tape_rd_q;
							out_valid_q <= 1'b1;
						end
						CH_COMMA: begin
							if (!valid_q && !eof_q) begin
								need_q <= 1'b1;
								pc_q   <= pc_q;
							end
						end
						CH_LBR, CH_RBR: begin
							if (!cmd_matched) begin
								status_q <= ST_UNBAL;
								pc_q     <= pc_q;
							end else if (loop_jump) begin
								pc_q <= PW'(cmd_partner) + PW'(1);
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign out_byte   = out_byte_q;
	assign out_valid  = out_valid_q;
	assign need_input = need_q;
	assign run_status = status_q;

	`TLI_ASSERT(a_len_range, 1'b1, len_q <= PW'(PROG_BYTES))
	`TLI_ASSERT(a_top_range, 1'b1, top_q <= ST'(NEST_DEPTH))
	`TLI_ASSERT_NEXT(a_exec_pc, op == DP_EXEC && status_q == ST_RUN, pc_q <= len_q)

endmodule

`default_nettype wire

/* rtl/tli_ctrl.sv */
// ----------------------------------------------------------------------------
// tli_ctrl
// Request sequencer: issues datapath operations and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tli_ctrl import tli_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	output logic          done,
	input  wire tli_sts_t sts,
	output tli_op_t       op
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_PAIR_OPEN,
		S_PAIR_CLOSE,
		S_CLEAR,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_comb begin
		op = DP_NOP;
		unique case (state_q)
			S_IDLE: op = start ? DP_CAPTURE : DP_NOP;
			S_DISPATCH: begin
				unique case (sts.req)
					REQ_LOAD:  op = sts.load_err ? DP_NOP : DP_LOAD;
					REQ_START: op = sts.load_err ? DP_NOP : DP_START;
					REQ_TICK:  op = (sts.running && !sts.can_run) ? DP_TICK_END : DP_NOP;
					default:   op = DP_NOP;
				endcase
			end
			S_PAIR_OPEN:  op = DP_PAIR_OPEN;
			S_PAIR_CLOSE: op = DP_PAIR_CLOSE;
			S_CLEAR:      op = DP_CLEAR;
			S_EXEC:       op = DP_EXEC;
			default:      op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					unique case (sts.req)
						REQ_LOAD: begin
							if (!sts.load_err && sts.pair_pending) begin
								state_q <= S_PAIR_OPEN;
							end else begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end
						end
						REQ_START: begin
							if (sts.load_err) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end else begin
								state_q <= S_CLEAR;
							end
						end
						REQ_TICK: begin
							if (sts.running && sts.can_run) begin
								state_q <= S_EXEC;
							end else begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end
						end
						default: begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					endcase
				end
				S_PAIR_OPEN: state_q <= S_PAIR_CLOSE;
				S_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_PAIR_CLOSE, S_EXEC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	`TLI_ASSERT_NEXT(a_done_single, done, !done)
	`TLI_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
	`TLI_ASSERT(a_done_idle, done, !busy)

endmodule

`default_nettype wire

/* rtl/tape_language_interpreter_unit.sv */
// Tick: capture, dispatch, execute if runnable; a new item is taken in the strobe cycle.
// Load: capture, dispatch; a pair-closing ']' adds two partner-table writes on one port.
// Start: capture, dispatch, then the tape clear sweep writing one cell per cycle.
// done pulses for one cycle; results hold till the next capture; the receiver cannot stall.
// Reset clears status, pointers, lengths, stack top; an error-free start clears the tape.
// ----------------------------------------------------------------------------
// tape_language_interpreter_unit
// Eight-command tape machine: program load with bracket pairing, run and step.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_language_interpreter_unit import tli_pkg::*; #(
	parameter int PROG_BYTES = 4096,
	parameter int TAPE_CELLS = 32768,
	parameter int NEST_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] req_type,
	input  wire logic [7:0] data_byte,
	input  wire logic       data_valid,
	input  wire logic       data_eof,
	output logic            done,
	output logic [7:0]      out_byte,
	output logic            out_valid,
	output logic            need_input,
	output logic [2:0]      run_status
);

	// Controller to datapath: one operation per cycle
	tli_op_t  op;
	// Datapath to controller: request kind and decision flags
	tli_sts_t sts;

	// Sequence each item: capture, dispatch, then load pairing, tape clear or execute
	tli_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.op     (op)
	);

	// Hold the program, partner table, stack and tape; drive the result fields
	tli_datapath #(
		.PROG_BYTES (PROG_BYTES),
		.TAPE_CELLS (TAPE_CELLS),
		.NEST_DEPTH (NEST_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.data_valid (data_valid),
		.data_eof   (data_eof),
		.op         (op),
		.sts        (sts),
		.out_byte   (out_byte),
		.out_valid  (out_valid),
		.need_input (need_input),
		.run_status (run_status)
	);

endmodule

`default_nettype wire
